### src/positional_integer_list_top_macros.svh
// Assertion helpers for the datapath RTL of the positional integer list.
// Each macro expects clk_i and rst_ni to be visible at the point of use.
`ifndef POSITIONAL_INTEGER_LIST_TOP_MACROS_SVH
`define POSITIONAL_INTEGER_LIST_TOP_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define PIL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define PIL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### src/pil_pkg.sv
// ----------------------------------------------------------------------------
// pil_pkg
// Shared types and constants of the positional integer list: operation and
// status codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package pil_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 8;
  localparam int OUT_IDX_W    = 7;

  localparam logic [OUT_IDX_W-1:0] FOUND_NONE = '1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_FIND   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_GET_RD,
    S_GET_DATA,
    S_REM_RD,
    S_REM_WR,
    S_FIND_RD,
    S_FIND_CHK,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    A_PTR,
    A_PTR_M1,
    A_PTR_P1
  } addr_sel_e;

  typedef struct packed {
    logic      load;       // latch a new operation
    logic      rd_en;
    addr_sel_e rd_sel;
    logic      wr_en;      // write at the pointer
    logic      wr_val;     // write the operand instead of the read data
    logic      ptr_inc;
    logic      ptr_dec;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      cap_item;
    logic      cap_found;
    logic      finish;     // move the result into the output register
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic err;
    logic ptr_gt_idx;
    logic rem_more;
    logic find_more;
    logic match;
    logic out_free;
  } sts_t;

endpackage

### src/positional_integer_list_top.sv
// ----------------------------------------------------------------------------
// positional_integer_list_top
// Ordered list of signed 32-bit integers with insert, remove, read and find.
// ----------------------------------------------------------------------------
// Usage: one operation per transfer on the input channel (op_i, position_i,
// value_i); exactly one result per operation on the output channel
// (status_o, item_out_o, found_index_o, count_o). Both channels are
// valid/ready. The list lives in a CAPACITY-deep RAM with one write port and
// one registered read port; every entry moved or compared is first read and
// then written back or compared in a state of its own. Insert and remove
// move the entries behind the target; find scans from index 0 until a match
// or the end of the list. One operation is worked on at a time; the next one
// is taken once the current result has reached the output register, where it
// waits while the receiver stalls. Reset empties the list at once (no
// clearing pass).
// ----------------------------------------------------------------------------
module positional_integer_list_top #(
  parameter int CAPACITY = pil_pkg::CAPACITY_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic          [1:0]                    op_i,
  input  logic signed   [pil_pkg::POS_W-1:0]     position_i,
  input  logic signed   [pil_pkg::DATA_W-1:0]    value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic          [1:0]                    status_o,
  output logic signed   [pil_pkg::DATA_W-1:0]    item_out_o,
  output logic signed   [pil_pkg::OUT_IDX_W-1:0] found_index_o,
  output logic          [pil_pkg::OUT_IDX_W-1:0] count_o
);

  import pil_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pil_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pil_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (op_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .item_out_o    (item_out_o),
    .found_index_o (found_index_o),
    .count_o       (count_o)
  );

endmodule

### src/pil_ram.sv
// ----------------------------------------------------------------------------
// pil_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pil_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### src/pil_dp.sv
// ----------------------------------------------------------------------------
// pil_dp
// Datapath of the positional integer list: operation decode, item count,
// walking pointer, entry RAM, result registers and the output register.
// ----------------------------------------------------------------------------
`include "positional_integer_list_top_macros.svh"

module pil_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  pil_pkg::cmd_t                           cmd_i,
  output pil_pkg::sts_t                           sts_o,
  input  logic          [1:0]                     op_i,
  input  logic signed   [pil_pkg::POS_W-1:0]      position_i,
  input  logic signed   [pil_pkg::DATA_W-1:0]     value_i,
  input  logic                                    out_ready_i,
  output logic                                    out_valid_o,
  output logic          [1:0]                     status_o,
  output logic signed   [pil_pkg::DATA_W-1:0]     item_out_o,
  output logic signed   [pil_pkg::OUT_IDX_W-1:0]  found_index_o,
  output logic          [pil_pkg::OUT_IDX_W-1:0]  count_o
);

  import pil_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W - 1) ? CNT_W : POS_W - 1;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     ptr_q, ptr_d;
  logic [CNT_W-1:0]     idx_q;
  op_e                  op_q;
  status_e              status_q;
  logic [DATA_W-1:0]    val_q;
  logic [DATA_W-1:0]    item_q;
  logic [OUT_IDX_W-1:0] found_q;

  logic                 out_valid_q;
  status_e              out_status_q;
  logic [DATA_W-1:0]    out_item_q;
  logic [OUT_IDX_W-1:0] out_found_q;
  logic [OUT_IDX_W-1:0] out_count_q;

  // Decode of the incoming operation against the current count.
  op_e              op_in;
  logic             empty, full, pos_m1, pos_lt, pos_ge;
  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] cnt_w;
  logic [CNT_W-1:0] last_idx;
  status_e          dec_status;
  logic [CNT_W-1:0] dec_idx;
  logic [CNT_W-1:0] dec_ptr;

  assign op_in    = op_e'(op_i);
  assign empty    = (count_q == '0);
  assign full     = (count_q == CAP_C);
  assign pos_m1   = (position_i == -1);
  assign pos_lt   = position_i[POS_W-1] && !pos_m1;
  assign pos_w    = CMP_W'(position_i[POS_W-2:0]);
  assign cnt_w    = CMP_W'(count_q);
  assign pos_ge   = !position_i[POS_W-1] && (pos_w >= cnt_w);
  assign last_idx = count_q - CNT_W'(1);

  always_comb begin
    dec_status = ST_OK;
    dec_idx    = '0;
    dec_ptr    = '0;
    unique case (op_in)
      OP_INSERT: begin
        dec_ptr = count_q;
        if (full) begin
          dec_status = ST_FULL;
        end else if (empty) begin
          dec_idx = '0;
        end else if (pos_m1 || pos_ge) begin
          dec_idx = count_q;
        end else if (pos_lt) begin
          dec_status = ST_RANGE;
        end else begin
          dec_idx = pos_w[CNT_W-1:0];
        end
      end
      OP_REMOVE, OP_READ: begin
        if (empty || pos_lt || pos_ge) begin
          dec_status = ST_RANGE;
        end else if (pos_m1) begin
          dec_idx = last_idx;
        end else begin
          dec_idx = pos_w[CNT_W-1:0];
        end
        dec_ptr = dec_idx;
      end
      OP_FIND: begin
        dec_ptr = '0;
      end
      default: begin
        dec_status = ST_OK;
      end
    endcase
  end

  // Entry memory.
  logic [CNT_W-1:0]  ptr_m1, ptr_p1, rd_ptr;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] wr_data;

  assign ptr_m1 = ptr_q - CNT_W'(1);
  assign ptr_p1 = ptr_q + CNT_W'(1);

  always_comb begin
    case (cmd_i.rd_sel)
      A_PTR_M1: rd_ptr = ptr_m1;
      A_PTR_P1: rd_ptr = ptr_p1;
      default:  rd_ptr = ptr_q;
    endcase
  end

  assign wr_data = cmd_i.wr_val ? val_q : rd_data;

  pil_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.wr_en),
    .wr_addr_i (ptr_q[IDX_W-1:0]),
    .wr_data_i (wr_data),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (rd_ptr[IDX_W-1:0]),
    .rd_data_o (rd_data)
  );

  // Pointer and count.
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.load) begin
      ptr_d = dec_ptr;
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_p1;
    end else if (cmd_i.ptr_dec) begin
      ptr_d = ptr_m1;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Masking of pointer and count to the seven-bit result fields.
  logic [CNT_W+OUT_IDX_W-1:0] ptr_ext, cnt_ext;

  assign ptr_ext = {{OUT_IDX_W{1'b0}}, ptr_q};
  assign cnt_ext = {{OUT_IDX_W{1'b0}}, count_q};

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.load) begin
      op_q     <= op_in;
      status_q <= dec_status;
      idx_q    <= dec_idx;
      val_q    <= value_i;
      item_q   <= '0;
      found_q  <= (op_in == OP_FIND && dec_status == ST_OK) ? FOUND_NONE : '0;
    end else begin
      if (cmd_i.cap_item) begin
        item_q <= rd_data;
      end
      if (cmd_i.cap_found) begin
        found_q <= ptr_ext[OUT_IDX_W-1:0];
      end
    end
  end

  // Output register; a finished result waits here until it is transferred.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_status_q <= status_q;
      out_item_q   <= item_q;
      out_found_q  <= found_q;
      out_count_q  <= cnt_ext[OUT_IDX_W-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign item_out_o    = out_item_q;
  assign found_index_o = out_found_q;
  assign count_o       = out_count_q;

  // Status toward the controller.
  logic [CNT_W:0] ptr_p1_w, cnt_w1;

  assign ptr_p1_w = {1'b0, ptr_q} + (CNT_W + 1)'(1);
  assign cnt_w1   = {1'b0, count_q};

  assign sts_o.op         = op_q;
  assign sts_o.err        = (status_q != ST_OK);
  assign sts_o.ptr_gt_idx = (ptr_q > idx_q);
  assign sts_o.rem_more   = (ptr_p1_w < cnt_w1);
  assign sts_o.find_more  = (ptr_q < count_q);
  assign sts_o.match      = (rd_data == val_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  `PIL_ASSERT(a_count_bound, count_q <= CAP_C, "item count above capacity")
  `PIL_ASSERT_IMP(a_wr_in_range, cmd_i.wr_en, ptr_q < CAP_C, "entry write beyond capacity")
  `PIL_ASSERT_IMP(a_full_status, cmd_i.finish && status_q == ST_FULL, count_q == CAP_C,
                  "full status reported on a list that is not full")

endmodule

### src/pil_ctrl.sv
// ----------------------------------------------------------------------------
// pil_ctrl
// Controller of the positional integer list: sequences the shift, fetch and
// scan loops over the entry RAM and hands the result to the output register.
// ----------------------------------------------------------------------------
module pil_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pil_pkg::sts_t sts_i,
  output pil_pkg::cmd_t cmd_o
);

  import pil_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.err) begin
          state_d = S_DONE;
        end else begin
          unique case (sts_i.op) inside
            OP_INSERT:          state_d = S_INS_RD;
            OP_REMOVE, OP_READ: state_d = S_GET_RD;
            default:            state_d = S_FIND_RD;
          endcase
        end
      end
      S_INS_RD:   state_d = sts_i.ptr_gt_idx ? S_INS_WR : S_INS_PUT;
      S_INS_WR:   state_d = S_INS_RD;
      S_INS_PUT:  state_d = S_DONE;
      S_GET_RD:   state_d = S_GET_DATA;
      S_GET_DATA: state_d = (sts_i.op == OP_REMOVE) ? S_REM_RD : S_DONE;
      S_REM_RD:   state_d = sts_i.rem_more ? S_REM_WR : S_DONE;
      S_REM_WR:   state_d = S_REM_RD;
      S_FIND_RD:  state_d = sts_i.find_more ? S_FIND_CHK : S_DONE;
      S_FIND_CHK: state_d = sts_i.match ? S_DONE : S_FIND_RD;
      S_DONE: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    cmd_o.rd_sel = A_PTR;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_INS_RD: begin
        if (sts_i.ptr_gt_idx) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = A_PTR_M1;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.ptr_dec = 1'b1;
      end
      S_INS_PUT: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_val  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
      end
      S_GET_RD: begin
        cmd_o.rd_en = 1'b1;
      end
      S_GET_DATA: begin
        cmd_o.cap_item = 1'b1;
      end
      S_REM_RD: begin
        if (sts_i.rem_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = A_PTR_P1;
        end else begin
          cmd_o.cnt_dec = 1'b1;
        end
      end
      S_REM_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.ptr_inc = 1'b1;
      end
      S_FIND_RD: begin
        cmd_o.rd_en = sts_i.find_more;
      end
      S_FIND_CHK: begin
        if (sts_i.match) begin
          cmd_o.cap_found = 1'b1;
        end else begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      S_DONE: begin
        cmd_o.finish = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule
